// ===== src/arpc_pkg.sv =====
package arpc_pkg;

  // Table size default
  localparam int TABLE_ENTRIES_DEF = 16;

  // Packet checks
  localparam logic [15:0] MIN_PACKET_BYTES = 16'd28;
  localparam logic [15:0] HW_ETHERNET      = 16'h0001;
  localparam logic [15:0] PROTO_IPV4       = 16'h0800;
  localparam logic [15:0] OP_REQUEST       = 16'h0001;

  // Item modes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_PACKET = 1'b1;

  // Result outcomes
  localparam logic [2:0] OUT_HIT   = 3'd0;
  localparam logic [2:0] OUT_MISS  = 3'd1;
  localparam logic [2:0] OUT_DROP  = 3'd2;
  localparam logic [2:0] OUT_LEARN = 3'd3;
  localparam logic [2:0] OUT_REPLY = 3'd4;

  // Register selects (paddr bit 3)
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // One cache entry as stored in the RAM
  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ===== src/arpc_ram.sv =====
module arpc_ram #(
  parameter int WIDTH  = 80,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/arp_cache_and_responder.sv =====
// A dropped packet goes from acceptance straight to the result stage; any other item
// scans the table one entry per cycle through a single RAM read port, giving its result
// after the scan ends at the first matching entry, or at the last entry with no match.
// A new item is accepted only in the idle state, once the last result has been loaded for output.
// Reset (synchronous, rst high) clears all valid bits at once, so the cache starts empty,
// and clears own_ip and own_mac; there is no clearing pass.
module arp_cache_and_responder #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // request in
  input  logic         s_tvalid,
  output logic         s_tready,
  // ip_address[31:0], snd_mac[79:32], tgt_ip[111:80], hardware_type[127:112],
  // protocol_type[143:128], arp_opcode[159:144], packet_length[175:160]
  input  logic [175:0] s_tdata,
  // mode[0]
  input  logic         s_tuser,
  // result out
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_mac[47:0], reply_target_ip[79:48]
  output logic [79:0]  m_tdata,
  // outcome[2:0]
  output logic [2:0]   m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam int ENTRY_W = $bits(arpc_pkg::entry_t);

  arpc_pkg::state_t state;

  logic [31:0] own_ip;
  logic [47:0] own_mac;

  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic        item_mode;
  logic [31:0] item_ip;
  logic [47:0] item_smac;
  logic [31:0] item_tip;
  logic [15:0] item_opc;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_pending;
  logic             free_found;
  logic [IDX_W-1:0] spare_idx;

  logic [2:0]  res_outcome;
  logic [47:0] res_mac;
  logic [31:0] res_ip;

  logic        out_valid;
  logic [2:0]  out_outcome;
  logic [47:0] out_mac;
  logic [31:0] out_ip;

  logic               in_fire;
  logic [ENTRY_W-1:0] ram_rdata;
  arpc_pkg::entry_t   rd_entry;
  arpc_pkg::entry_t   wr_entry;
  logic               cur_valid;
  logic               match;
  logic               scan_end;
  logic               have_free;
  logic [IDX_W-1:0]   slot_free;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               reply;
  logic               bad_pkt;
  logic               out_load;
  logic               cfg_wr;

  // Input field views
  logic [31:0] in_ip;
  logic [47:0] in_smac;
  logic [31:0] in_tip;
  logic [15:0] in_hwt;
  logic [15:0] in_prt;
  logic [15:0] in_opc;
  logic [15:0] in_plen;

  assign in_ip   = s_tdata[31:0];
  assign in_smac = s_tdata[79:32];
  assign in_tip  = s_tdata[111:80];
  assign in_hwt  = s_tdata[127:112];
  assign in_prt  = s_tdata[143:128];
  assign in_opc  = s_tdata[159:144];
  assign in_plen = s_tdata[175:160];

  assign s_tready = (state == arpc_pkg::S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign bad_pkt  = (in_plen < arpc_pkg::MIN_PACKET_BYTES) ||
                    (in_hwt != arpc_pkg::HW_ETHERNET) ||
                    (in_prt != arpc_pkg::PROTO_IPV4);

  // Compare the entry read last cycle against the key
  assign rd_entry  = arpc_pkg::entry_t'(ram_rdata);
  assign cur_valid = entry_valid[cmp_idx];
  assign match     = cur_valid && (rd_entry.ip == item_ip);
  assign scan_end  = (state == arpc_pkg::S_SCAN) && cmp_pending &&
                     (match || (cmp_idx == LAST_IDX));
  assign have_free = free_found || !cur_valid;
  assign slot_free = free_found ? spare_idx : cmp_idx;
  assign reply     = (item_opc == arpc_pkg::OP_REQUEST) && (item_tip == own_ip);

  // Learn the sender when the scan ends
  assign wr_en   = scan_end && (item_mode == arpc_pkg::MODE_PACKET) && (match || have_free);
  assign wr_addr = match ? cmp_idx : slot_free;
  assign wr_entry.mac = item_smac;
  assign wr_entry.ip  = item_ip;

  arpc_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign out_load = (state == arpc_pkg::S_DONE) && (!out_valid || m_tready);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= arpc_pkg::S_IDLE;
      entry_valid <= '0;
      cmp_pending <= 1'b0;
      free_found  <= 1'b0;
      out_valid   <= 1'b0;
      scan_idx    <= '0;
    end else begin
      case (state)
        arpc_pkg::S_IDLE: begin
          if (in_fire) begin
            scan_idx    <= '0;
            cmp_pending <= 1'b0;
            free_found  <= 1'b0;
            if (s_tuser == arpc_pkg::MODE_PACKET && bad_pkt) begin
              state <= arpc_pkg::S_DONE;
            end else begin
              state <= arpc_pkg::S_SCAN;
            end
          end
        end
        arpc_pkg::S_SCAN: begin
          // advance the read address, holding at the last entry
          cmp_pending <= 1'b1;
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (cmp_pending && !cur_valid && !free_found) begin
            free_found <= 1'b1;
          end
          if (wr_en && !match) begin
            entry_valid[wr_addr] <= 1'b1;
          end
          if (scan_end) begin
            state <= arpc_pkg::S_DONE;
          end
        end
        arpc_pkg::S_DONE: begin
          if (out_load) begin
            state <= arpc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= arpc_pkg::S_IDLE;
        end
      endcase

      // hold the result until taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, scan and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_mode <= s_tuser;
      item_ip   <= in_ip;
      item_smac <= in_smac;
      item_tip  <= in_tip;
      item_opc  <= in_opc;
      res_outcome <= arpc_pkg::OUT_DROP;
      res_mac     <= '0;
      res_ip      <= '0;
    end
    if (state == arpc_pkg::S_SCAN) begin
      cmp_idx <= scan_idx;
      if (cmp_pending && !cur_valid && !free_found) begin
        spare_idx <= cmp_idx;
      end
    end
    if (scan_end) begin
      if (item_mode == arpc_pkg::MODE_LOOKUP) begin
        res_outcome <= match ? arpc_pkg::OUT_HIT : arpc_pkg::OUT_MISS;
        res_mac     <= match ? rd_entry.mac : 48'd0;
        res_ip      <= '0;
      end else if (reply) begin
        res_outcome <= arpc_pkg::OUT_REPLY;
        res_mac     <= item_smac;
        res_ip      <= item_ip;
      end else begin
        res_outcome <= arpc_pkg::OUT_LEARN;
        res_mac     <= '0;
        res_ip      <= '0;
      end
    end
    if (out_load) begin
      out_outcome <= res_outcome;
      out_mac     <= res_mac;
      out_ip      <= res_ip;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_outcome;
  assign m_tdata  = {out_ip, out_mac};

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        arpc_pkg::REG_OWN_IP:  own_ip  <= pwdata[31:0];
        arpc_pkg::REG_OWN_MAC: own_mac <= pwdata[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      arpc_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip};
      arpc_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac};
      default:               prdata = '0;
    endcase
  end

endmodule
